>>> src/mpec_pkg.sv
package mpec_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int FRAC_BITS       = 28;
    localparam int INDEX_WIDTH     = 10;
    localparam int LIMIT_WIDTH     = 10;
    localparam int COUNT_WIDTH     = LIMIT_WIDTH + 1;
    localparam int WIDE_WIDTH      = 2 * COORD_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-2:0] ucoord_t;
    typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
    typedef logic        [LIMIT_WIDTH-1:0] limit_t;
    typedef logic        [COUNT_WIDTH-1:0] count_t;

    localparam limit_t MAX_LIMIT = LIMIT_WIDTH'(1023);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_REAL     = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ORIGIN_IMAG     = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_REAL       = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_IMAG       = CFG_INDEX_WIDTH'(3);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITERATION_LIMIT = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ESCAPE_BOUND    = CFG_INDEX_WIDTH'(5);

    // Reset values: -2.0, -1.5, 3/480, 3/272, 360 and 2.0 in Q4.28.
    localparam coord_t  ORIGIN_REAL_RST = coord_t'(-536870912);
    localparam coord_t  ORIGIN_IMAG_RST = coord_t'(-402653184);
    localparam ucoord_t STEP_REAL_RST   = ucoord_t'(1677722);
    localparam ucoord_t STEP_IMAG_RST   = ucoord_t'(2960685);
    localparam limit_t  LIMIT_RST       = LIMIT_WIDTH'(360);
    localparam ucoord_t BOUND_RST       = ucoord_t'(536870912);

    localparam wide_t WIDE_MAX =
        {{(WIDE_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam wide_t WIDE_MIN = ~WIDE_MAX;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] column;
        logic [INDEX_WIDTH-1:0] row;
    } pixel_t;

    typedef struct packed {
        count_t iteration_count;
        logic   inside_set;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_ORIGIN,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Clamp a wide signed value to the signed coordinate range.
    function automatic coord_t sat_coord(wide_t v);
        coord_t r;
        if (v > WIDE_MAX)
        begin
            r = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        end
        else if (v < WIDE_MIN)
        begin
            r = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        end
        else
        begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/mandelbrot_pixel_escape_count_top.sv
// Escape-time counter for one Mandelbrot pixel. Each item (column, row) is mapped to
// c = origin + index * step in signed Q4.28, and z = z*z + c is iterated from zero on a
// set of three 32x32 multipliers that also forms the index products. Each pass has two
// steps (multiply, then round, saturate, escape test and update). The number of multiply
// passes is iteration_count + 1 when the point escapes, iteration_count when it reaches
// the limit. The input is stalled while an item is in work; a finished result waits in an
// output register while the next item is taken, and if that register is still full and
// stalled the block holds in its done state until it empties. Products round toward minus
// infinity, and the rounded products, c, x and y saturate to the 32-bit range.
module mandelbrot_pixel_escape_count_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  mpec_pkg::pixel_t                       pixel,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output mpec_pkg::result_t                      result,
    input  logic                                   cfg_write,
    input  logic [mpec_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mpec_pkg::COORD_WIDTH-1:0]       cfg_data
);
    import mpec_pkg::*;

    coord_t  origin_real_reg;
    coord_t  origin_imag_reg;
    ucoord_t step_real_reg;
    ucoord_t step_imag_reg;
    limit_t  limit_reg;
    ucoord_t bound_reg;

    state_t  state_reg, state_next;
    pixel_t  pixel_reg, pixel_next;
    count_t  count_reg, count_next;
    coord_t  x_reg, x_next;
    coord_t  y_reg, y_next;
    coord_t  cre_reg, cre_next;
    coord_t  cim_reg, cim_next;
    wide_t   prod_a_reg, prod_a_next;
    wide_t   prod_b_reg, prod_b_next;
    wide_t   prod_c_reg, prod_c_next;
    result_t result_reg, result_next;
    logic    result_valid_reg, result_valid_next;

    coord_t  op_a0, op_b0, op_a1, op_b1, op_a2, op_b2;
    coord_t  x2, y2, xy2;
    wide_t   mag;
    logic    escape;
    count_t  count_inc;
    limit_t  limit_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg <= ORIGIN_REAL_RST;
            origin_imag_reg <= ORIGIN_IMAG_RST;
            step_real_reg   <= STEP_REAL_RST;
            step_imag_reg   <= STEP_IMAG_RST;
            limit_reg       <= LIMIT_RST;
            bound_reg       <= BOUND_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORIGIN_REAL:     origin_real_reg <= coord_t'(cfg_data);
                CFG_ORIGIN_IMAG:     origin_imag_reg <= coord_t'(cfg_data);
                CFG_STEP_REAL:       step_real_reg   <= cfg_data[COORD_WIDTH-2:0];
                CFG_STEP_IMAG:       step_imag_reg   <= cfg_data[COORD_WIDTH-2:0];
                CFG_ITERATION_LIMIT: limit_reg       <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_ESCAPE_BOUND:    bound_reg       <= cfg_data[COORD_WIDTH-2:0];
                default:
                begin
                end
            endcase
        end
    end

    // The multiplier set forms the index products while the point is set up and the
    // squares and cross product during the iteration.
    always_comb
    begin
        if (state_reg == ST_COORD)
        begin
            op_a0 = coord_t'({{(COORD_WIDTH - INDEX_WIDTH){1'b0}}, pixel_reg.column});
            op_b0 = coord_t'({1'b0, step_real_reg});
            op_a1 = coord_t'({{(COORD_WIDTH - INDEX_WIDTH){1'b0}}, pixel_reg.row});
            op_b1 = coord_t'({1'b0, step_imag_reg});
        end
        else
        begin
            op_a0 = x_reg;
            op_b0 = x_reg;
            op_a1 = y_reg;
            op_b1 = y_reg;
        end
        op_a2 = x_reg;
        op_b2 = y_reg;
    end

    assign prod_a_next = wide_t'(op_a0) * wide_t'(op_b0);
    assign prod_b_next = wide_t'(op_a1) * wide_t'(op_b1);
    assign prod_c_next = wide_t'(op_a2) * wide_t'(op_b2);

    // Arithmetic shift of the exact product rounds toward minus infinity.
    assign x2  = sat_coord(prod_a_reg >>> FRAC_BITS);
    assign y2  = sat_coord(prod_b_reg >>> FRAC_BITS);
    assign xy2 = sat_coord(prod_c_reg >>> (FRAC_BITS - 1));

    assign mag       = wide_t'(x2) + wide_t'(y2);
    assign escape    = (mag >= wide_t'(bound_reg));
    assign count_inc = count_reg + COUNT_WIDTH'(1);
    assign limit_eff = (limit_reg > MAX_LIMIT) ? MAX_LIMIT : limit_reg;

    always_comb
    begin
        state_next        = state_reg;
        pixel_next        = pixel_reg;
        count_next        = count_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        cre_next          = cre_reg;
        cim_next          = cim_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    pixel_next = pixel;
                    state_next = ST_COORD;
                end
            end
            ST_COORD:
            begin
                state_next = ST_ORIGIN;
            end
            ST_ORIGIN:
            begin
                cre_next   = sat_coord(wide_t'(origin_real_reg) + prod_a_reg);
                cim_next   = sat_coord(wide_t'(origin_imag_reg) + prod_b_reg);
                x_next     = '0;
                y_next     = '0;
                count_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    x_next     = sat_coord(wide_t'(x2) - wide_t'(y2) + wide_t'(cre_reg));
                    y_next     = sat_coord(wide_t'(xy2) + wide_t'(cim_reg));
                    count_next = count_inc;
                    if (count_inc > {1'b0, limit_eff})
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.iteration_count = count_reg;
                    result_next.inside_set      = (count_reg >= {1'b0, limit_eff});
                    result_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg  <= pixel_next;
        count_reg  <= count_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        cre_reg    <= cre_next;
        cim_reg    <= cim_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        prod_c_reg <= prod_c_next;
        result_reg <= result_next;
    end

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
